>>> rtl/pcfs_pkg.sv
package pcfs_pkg;

    localparam int SAMPLE_W = 8;
    localparam int POWER_W  = 16;
    localparam int COUNT_W  = 16;
    localparam int NERV_W   = 8;
    localparam int LEVEL_W  = 8;
    localparam int THR_W    = 9;
    localparam int BOOST_W  = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef logic [CFG_IDX_W-1:0]  cfg_index_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;
    typedef logic [POWER_W-1:0]    power_t;
    typedef logic [COUNT_W-1:0]    count_t;
    typedef logic [NERV_W-1:0]     nerv_t;
    typedef logic [LEVEL_W-1:0]    level_t;

    typedef struct packed {
        level_t red;
        level_t green;
        level_t blue;
    } led_t;

    // register indexes
    localparam cfg_index_t REG_FLASH_THRESHOLD     = 3'd0;
    localparam cfg_index_t REG_FIRE_LEVEL          = 3'd1;
    localparam cfg_index_t REG_BOOST_AMOUNT        = 3'd2;
    localparam cfg_index_t REG_DAYLIGHT_LEVEL      = 3'd3;
    localparam cfg_index_t REG_BLIND_OTHER_TICKS   = 3'd4;
    localparam cfg_index_t REG_BLIND_SELF_TICKS    = 3'd5;
    localparam cfg_index_t REG_FLASH_HOLD_TICKS    = 3'd6;
    localparam cfg_index_t REG_DAYLIGHT_HOLD_TICKS = 3'd7;

    // power step bands
    localparam power_t POWER_BAND_1 = 16'd6000;
    localparam power_t POWER_BAND_2 = 16'd4000;
    localparam power_t POWER_BAND_4 = 16'd3000;
    localparam power_t POWER_BAND_8 = 16'd2000;
    localparam power_t NERVOUS_HIGH = 16'd7000;

    localparam nerv_t NERV_MAX     = 8'd168;
    localparam nerv_t NERV_SAT     = 8'd158;
    localparam nerv_t NERV_UP      = 8'd10;
    localparam nerv_t NERV_DOWN    = 8'd5;
    localparam nerv_t NERV_FIRE    = 8'd3;
    localparam nerv_t HUE_MAX      = 8'd168;

    localparam level_t HUE_SEG_LEN = 8'd42;
    localparam level_t LED_FULL    = 8'd252;
    localparam level_t DAY_GREEN   = 8'd32;

    localparam logic [2:0] SEG_RED_YELLOW   = 3'd0;
    localparam logic [2:0] SEG_YELLOW_GREEN = 3'd1;
    localparam logic [2:0] SEG_GREEN_CYAN   = 3'd2;
    localparam logic [2:0] SEG_CYAN_BLUE    = 3'd3;
    localparam logic [2:0] SEG_BLUE_MAGENTA = 3'd4;

    function automatic led_t hue_to_led(input level_t hue);
        logic [2:0] seg;
        level_t     base;
        level_t     rem;
        level_t     ramp;
        led_t       c;
        if (hue >= 4 * HUE_SEG_LEN) begin
            seg  = SEG_BLUE_MAGENTA;
            base = level_t'(4 * HUE_SEG_LEN);
        end else if (hue >= 3 * HUE_SEG_LEN) begin
            seg  = SEG_CYAN_BLUE;
            base = level_t'(3 * HUE_SEG_LEN);
        end else if (hue >= 2 * HUE_SEG_LEN) begin
            seg  = SEG_GREEN_CYAN;
            base = level_t'(2 * HUE_SEG_LEN);
        end else if (hue >= HUE_SEG_LEN) begin
            seg  = SEG_YELLOW_GREEN;
            base = HUE_SEG_LEN;
        end else begin
            seg  = SEG_RED_YELLOW;
            base = '0;
        end
        rem  = hue - base;
        ramp = (rem << 2) + (rem << 1);
        case (seg)
            SEG_RED_YELLOW:   c = '{red: LED_FULL, green: ramp, blue: '0};
            SEG_YELLOW_GREEN: c = '{red: LED_FULL - ramp, green: LED_FULL, blue: '0};
            SEG_GREEN_CYAN:   c = '{red: '0, green: LED_FULL, blue: ramp};
            SEG_CYAN_BLUE:    c = '{red: '0, green: LED_FULL - ramp, blue: LED_FULL};
            SEG_BLUE_MAGENTA: c = '{red: ramp, green: '0, blue: LED_FULL};
            default:          c = '{red: LED_FULL, green: '0, blue: LED_FULL - ramp};
        endcase
        return c;
    endfunction

endpackage

>>> rtl/pulse_coupled_flash_sync.sv
// Firefly-style flash synchronizer. Each request on the input channel is one tick carrying a
// light sample; each tick gives exactly one result with the LED color, event flags, nervousness
// and power after that tick. A request is staged in an input register, the whole tick update is
// one pass of combinational logic, and the result lands in an output register, so one request
// is taken every clock cycle as long as results are taken; the result is written to the output
// register when the staged request advances. The stall path is the result register: while it
// holds an untaken result and the stage is full, input ready drops. Configuration writes are
// taken in any cycle (ready is always high) and must only be issued while no tick is in flight.
module pulse_coupled_flash_sync
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  pcfs_pkg::cfg_index_t  cfg_index,
    input  pcfs_pkg::cfg_data_t   cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            light_sample,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            red_level,
    output logic [7:0]            green_level,
    output logic [7:0]            blue_level,
    output logic                  fired,
    output logic                  daylight_seen,
    output logic                  holding,
    output logic [7:0]            nervous_level,
    output logic [15:0]           power_level
);
    import pcfs_pkg::*;

    // configuration
    logic [THR_W-1:0]   flash_threshold_reg;
    power_t             fire_level_reg;
    logic [BOOST_W-1:0] boost_amount_reg;
    level_t             daylight_level_reg;
    count_t             blind_other_reg;
    count_t             blind_self_reg;
    count_t             flash_hold_reg;
    count_t             day_hold_reg;

    // tick state
    power_t power_reg,  power_next;
    nerv_t  nerv_reg,   nerv_next;
    count_t blind_reg,  blind_next;
    count_t hold_reg,   hold_next;
    led_t   led_reg,    led_next;

    // input stage
    logic                 stage_valid_reg;
    logic [SAMPLE_W-1:0]  sample_reg;

    // result stage
    logic   out_valid_reg;
    led_t   res_led_reg,   res_led_next;
    logic   res_fired_reg, res_fired_next;
    logic   res_day_reg,   res_day_next;
    logic   res_hold_reg,  res_hold_next;

    logic   advance;
    power_t step;
    power_t p1;
    logic   clear_after;

    assign cfg_ready = 1'b1;
    assign advance   = stage_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !stage_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flash_threshold_reg <= THR_W'(20);
            fire_level_reg      <= 16'd8000;
            boost_amount_reg    <= BOOST_W'(400);
            daylight_level_reg  <= 8'd240;
            blind_other_reg     <= 16'd800;
            blind_self_reg      <= 16'd100;
            flash_hold_reg      <= 16'd400;
            day_hold_reg        <= 16'd20000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FLASH_THRESHOLD:     flash_threshold_reg <= cfg_data[THR_W-1:0];
                REG_FIRE_LEVEL:          fire_level_reg      <= cfg_data;
                REG_BOOST_AMOUNT:        boost_amount_reg    <= cfg_data[BOOST_W-1:0];
                REG_DAYLIGHT_LEVEL:      daylight_level_reg  <= cfg_data[LEVEL_W-1:0];
                REG_BLIND_OTHER_TICKS:   blind_other_reg     <= cfg_data;
                REG_BLIND_SELF_TICKS:    blind_self_reg      <= cfg_data;
                REG_FLASH_HOLD_TICKS:    flash_hold_reg      <= cfg_data;
                REG_DAYLIGHT_HOLD_TICKS: day_hold_reg        <= cfg_data;
                default: ;
            endcase
        end
    end

    // one tick update
    always_comb
    begin
        power_next     = power_reg;
        nerv_next      = nerv_reg;
        blind_next     = blind_reg;
        hold_next      = hold_reg;
        led_next       = led_reg;
        res_fired_next = 1'b0;
        res_day_next   = 1'b0;
        res_hold_next  = 1'b0;
        clear_after    = 1'b0;

        if (power_reg > POWER_BAND_1)
            step = 16'd1;
        else if (power_reg > POWER_BAND_2)
            step = 16'd2;
        else if (power_reg > POWER_BAND_4)
            step = 16'd4;
        else if (power_reg > POWER_BAND_8)
            step = 16'd8;
        else
            step = 16'd16;
        p1 = power_reg + step;

        if (hold_reg != '0)
        begin
            res_hold_next = 1'b1;
            hold_next     = hold_reg - 16'd1;
            clear_after   = (hold_next == '0);
        end
        else
        begin
            power_next = p1;
            if (blind_reg == '0)
            begin
                if (sample_reg > daylight_level_reg)
                begin
                    res_day_next = 1'b1;
                end
                else if ({1'b0, sample_reg} > flash_threshold_reg)
                begin
                    if (p1 > POWER_BAND_8 && p1 < NERVOUS_HIGH)
                        nerv_next = (nerv_reg >= NERV_SAT) ? NERV_MAX : nerv_reg + NERV_UP;
                    else if (nerv_reg > NERV_DOWN)
                        nerv_next = nerv_reg - NERV_DOWN;
                    power_next = p1 + POWER_W'(boost_amount_reg);
                    blind_next = blind_other_reg;
                end
            end
            else
            begin
                blind_next = blind_reg - 16'd1;
            end

            if (power_next > fire_level_reg)
            begin
                res_fired_next = 1'b1;
                led_next       = hue_to_led(HUE_MAX - nerv_next);
                power_next     = '0;
                blind_next     = blind_self_reg;
                if (nerv_next > NERV_FIRE)
                    nerv_next = nerv_next - NERV_FIRE;
                hold_next      = flash_hold_reg;
            end
            else if (res_day_next)
            begin
                led_next  = '{red: '0, green: DAY_GREEN, blue: '0};
                hold_next = day_hold_reg;
            end
            clear_after = (res_fired_next || res_day_next) && (hold_next == '0);
        end

        res_led_next = led_next;
        if (clear_after)
            led_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            power_reg       <= '0;
            nerv_reg        <= '0;
            blind_reg       <= '0;
            hold_reg        <= '0;
            led_reg         <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                stage_valid_reg <= 1'b1;
            else if (advance)
                stage_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (advance)
            begin
                power_reg <= power_next;
                nerv_reg  <= nerv_next;
                blind_reg <= blind_next;
                hold_reg  <= hold_next;
                led_reg   <= led_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            sample_reg <= light_sample;
        if (advance)
        begin
            res_led_reg   <= res_led_next;
            res_fired_reg <= res_fired_next;
            res_day_reg   <= res_day_next;
            res_hold_reg  <= res_hold_next;
        end
    end

    // nervousness and power results mirror the state registers
    logic [NERV_W-1:0]  res_nerv_reg;
    logic [POWER_W-1:0] res_power_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_nerv_reg  <= nerv_next;
            res_power_reg <= power_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign red_level     = res_led_reg.red;
    assign green_level   = res_led_reg.green;
    assign blue_level    = res_led_reg.blue;
    assign fired         = res_fired_reg;
    assign daylight_seen = res_day_reg;
    assign holding       = res_hold_reg;
    assign nervous_level = res_nerv_reg;
    assign power_level   = res_power_reg;

endmodule

>>> tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pcfs_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_STALL     = 300;
    localparam int PHASES         = 9;
    localparam int PHASE_TICKS    = 135;
    localparam int LONG_COUNT     = 8;

    typedef struct packed {
        level_t red;
        level_t green;
        level_t blue;
        logic   fired;
        logic   daylight;
        logic   holding;
        nerv_t  nervous;
        power_t power;
    } tick_result_t;

    typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t    kind;
        cfg_index_t   idx;
        cfg_data_t    data;
        level_t       sample;
        logic         typed;
        tick_result_t want;
    } row_t;

    logic       clk;
    logic       rst_n        = 1'b0;
    logic       cfg_valid    = 1'b0;
    logic       cfg_ready;
    cfg_index_t cfg_index    = '0;
    cfg_data_t  cfg_data     = '0;
    logic       in_valid     = 1'b0;
    logic       in_ready;
    level_t     light_sample = '0;
    logic       out_valid;
    logic       out_ready    = 1'b0;
    level_t     red_level;
    level_t     green_level;
    level_t     blue_level;
    logic       fired;
    logic       daylight_seen;
    logic       holding;
    nerv_t      nervous_level;
    power_t     power_level;

    // register shadow
    logic [THR_W-1:0]   thr_reg        = 9'd20;
    power_t             fire_reg       = 16'd8000;
    logic [BOOST_W-1:0] boost_reg      = 10'd400;
    level_t             day_reg        = 8'd240;
    count_t             blind_nbr_reg  = 16'd800;
    count_t             blind_self_reg = 16'd100;
    count_t             flash_hold_reg = 16'd400;
    count_t             day_hold_reg   = 16'd20000;

    // firefly state
    power_t power_acc   = '0;
    nerv_t  nervousness = '0;
    count_t blind_left  = '0;
    count_t hold_left   = '0;
    led_t   led_now     = '0;

    tick_result_t tick_results_due[$];
    int           errors        = 0;
    int           idle_cycles   = 0;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    logic         stall_req     = 1'b0;

    row_t directed_rows [25] = '{
        '{ROW_TICK, '0, '0, 8'd0,   1'b1, '{8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0, 8'd0, 16'd16}},
        '{ROW_TICK, '0, '0, 8'd20,  1'b1, '{8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0, 8'd0, 16'd32}},
        '{ROW_CFG, REG_BLIND_OTHER_TICKS, 16'd1, 8'd0, 1'b0, '0},
        '{ROW_CFG, REG_DAYLIGHT_HOLD_TICKS, 16'd0, 8'd0, 1'b0, '0},
        '{ROW_CFG, REG_FLASH_HOLD_TICKS, 16'd2, 8'd0, 1'b0, '0},
        '{ROW_CFG, REG_BLIND_SELF_TICKS, 16'd0, 8'd0, 1'b0, '0},
        '{ROW_TICK, '0, '0, 8'd21,  1'b1, '{8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0, 8'd0, 16'd448}},
        '{ROW_TICK, '0, '0, 8'd255, 1'b1, '{8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0, 8'd0, 16'd464}},
        '{ROW_TICK, '0, '0, 8'd255, 1'b1, '{8'd0, 8'd32, 8'd0, 1'b0, 1'b1, 1'b0, 8'd0, 16'd480}},
        '{ROW_TICK, '0, '0, 8'd0,   1'b1, '{8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0, 8'd0, 16'd496}},
        '{ROW_CFG, REG_FIRE_LEVEL, 16'd0, 8'd0, 1'b0, '0},
        '{ROW_TICK, '0, '0, 8'd255, 1'b1, '{8'd0, 8'd0, 8'd252, 1'b1, 1'b1, 1'b0, 8'd0, 16'd0}},
        '{ROW_TICK, '0, '0, 8'd0,   1'b1, '{8'd0, 8'd0, 8'd252, 1'b0, 1'b0, 1'b1, 8'd0, 16'd0}},
        '{ROW_TICK, '0, '0, 8'd0,   1'b1, '{8'd0, 8'd0, 8'd252, 1'b0, 1'b0, 1'b1, 8'd0, 16'd0}},
        '{ROW_TICK, '0, '0, 8'd0,   1'b1, '{8'd0, 8'd0, 8'd252, 1'b1, 1'b0, 1'b0, 8'd0, 16'd0}},
        '{ROW_CFG, REG_FIRE_LEVEL, 16'd60000, 8'd0, 1'b0, '0},
        '{ROW_CFG, REG_FLASH_THRESHOLD, 16'd511, 8'd0, 1'b0, '0},
        '{ROW_TICK, '0, '0, 8'd255, 1'b0, '0},
        '{ROW_CFG, REG_DAYLIGHT_LEVEL, 16'd255, 8'd0, 1'b0, '0},
        '{ROW_TICK, '0, '0, 8'd255, 1'b0, '0},
        '{ROW_TICK, '0, '0, 8'd128, 1'b0, '0},
        '{ROW_CFG, REG_BOOST_AMOUNT, 16'd1023, 8'd0, 1'b0, '0},
        '{ROW_CFG, REG_FLASH_THRESHOLD, 16'd0, 8'd0, 1'b0, '0},
        '{ROW_TICK, '0, '0, 8'd1,   1'b0, '0},
        '{ROW_TICK, '0, '0, 8'd0,   1'b0, '0}
    };

    pulse_coupled_flash_sync u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .light_sample  (light_sample),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .red_level     (red_level),
        .green_level   (green_level),
        .blue_level    (blue_level),
        .fired         (fired),
        .daylight_seen (daylight_seen),
        .holding       (holding),
        .nervous_level (nervous_level),
        .power_level   (power_level)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic led_t flash_colour(input nerv_t nerv);
        int   hue;
        int   ramp;
        led_t c;
        hue  = HUE_MAX - nerv;
        ramp = (hue % HUE_SEG_LEN) * 6;
        case (3'(hue / HUE_SEG_LEN))
            SEG_RED_YELLOW:   c = '{LED_FULL, level_t'(ramp), '0};
            SEG_YELLOW_GREEN: c = '{level_t'(LED_FULL - ramp), LED_FULL, '0};
            SEG_GREEN_CYAN:   c = '{'0, LED_FULL, level_t'(ramp)};
            SEG_CYAN_BLUE:    c = '{'0, level_t'(LED_FULL - ramp), LED_FULL};
            SEG_BLUE_MAGENTA: c = '{level_t'(ramp), '0, LED_FULL};
            default:          c = '{LED_FULL, '0, level_t'(LED_FULL - ramp)};
        endcase
        return c;
    endfunction

    function automatic tick_result_t advance_firefly(input level_t sample);
        tick_result_t r;
        logic         fire_now;
        logic         day_now;
        logic         absorbed;
        logic         led_off_after;
        power_t       step;
        fire_now      = 1'b0;
        day_now       = 1'b0;
        absorbed      = 1'b0;
        led_off_after = 1'b0;
        if (hold_left != 0)
        begin
            absorbed  = 1'b1;
            hold_left = hold_left - 1'b1;
            if (hold_left == 0)
                led_off_after = 1'b1;
        end
        else
        begin
            if (power_acc > POWER_BAND_1)
                step = 16'd1;
            else if (power_acc > POWER_BAND_2)
                step = 16'd2;
            else if (power_acc > POWER_BAND_4)
                step = 16'd4;
            else if (power_acc > POWER_BAND_8)
                step = 16'd8;
            else
                step = 16'd16;
            power_acc = power_acc + step;
            if (blind_left == 0)
            begin
                if (sample > day_reg)
                    day_now = 1'b1;
                else if (sample > thr_reg)
                begin
                    if (power_acc > POWER_BAND_8 && power_acc < NERVOUS_HIGH)
                        nervousness = (nervousness >= NERV_SAT) ? NERV_MAX
                                                                : nervousness + NERV_UP;
                    else if (nervousness > NERV_DOWN)
                        nervousness = nervousness - NERV_DOWN;
                    power_acc  = power_acc + power_t'(boost_reg);
                    blind_left = blind_nbr_reg;
                end
            end
            else
                blind_left = blind_left - 1'b1;
            if (power_acc > fire_reg)
            begin
                fire_now   = 1'b1;
                led_now    = flash_colour(nervousness);
                power_acc  = '0;
                blind_left = blind_self_reg;
                if (nervousness > NERV_FIRE)
                    nervousness = nervousness - NERV_FIRE;
                hold_left = flash_hold_reg;
            end
            else if (day_now)
            begin
                led_now   = '{'0, DAY_GREEN, '0};
                hold_left = day_hold_reg;
            end
            if ((fire_now || day_now) && hold_left == 0)
                led_off_after = 1'b1;
        end
        r = '{led_now.red, led_now.green, led_now.blue, fire_now, day_now, absorbed,
              nervousness, power_acc};
        if (led_off_after)
            led_now = '0;
        return r;
    endfunction

    task automatic send_tick(input level_t sample, input logic typed, input tick_result_t want);
        tick_result_t predicted;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        light_sample <= sample;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = advance_firefly(sample);
        tick_results_due.push_back(typed ? want : predicted);
    endtask

    task automatic drain_ticks();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tick_results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input cfg_data_t data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_FLASH_THRESHOLD:     thr_reg        = data[THR_W-1:0];
            REG_FIRE_LEVEL:          fire_reg       = data;
            REG_BOOST_AMOUNT:        boost_reg      = data[BOOST_W-1:0];
            REG_DAYLIGHT_LEVEL:      day_reg        = data[LEVEL_W-1:0];
            REG_BLIND_OTHER_TICKS:   blind_nbr_reg  = data;
            REG_BLIND_SELF_TICKS:    blind_self_reg = data;
            REG_FLASH_HOLD_TICKS:    flash_hold_reg = data;
            REG_DAYLIGHT_HOLD_TICKS: day_hold_reg   = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // random junk above the width of the threshold, boost and daylight registers
    task automatic program_phase(input int ph);
        logic      nervous_mix;
        int        roll;
        cfg_data_t v;
        nervous_mix = (ph % 3 == 2);

        v    = cfg_data_t'($urandom());
        roll = $urandom_range(0, 99);
        v[THR_W-1:0] = THR_W'(nervous_mix ? $urandom_range(10, 40) :
                       (roll < 10) ? 0 : (roll < 20) ? 511 : $urandom_range(5, 80));
        write_reg(REG_FLASH_THRESHOLD, v);

        roll = $urandom_range(0, 99);
        v = cfg_data_t'(nervous_mix ? $urandom_range(5000, 7000) :
            (roll < 10) ? 0 : (roll < 20) ? 65535 : $urandom_range(200, 4000));
        write_reg(REG_FIRE_LEVEL, v);

        v    = cfg_data_t'($urandom());
        roll = $urandom_range(0, 99);
        v[BOOST_W-1:0] = BOOST_W'(nervous_mix ? $urandom_range(0, 40) : (ph == 1) ? 0 :
                         (roll < 15) ? 1023 : $urandom_range(0, 600));
        write_reg(REG_BOOST_AMOUNT, v);

        v    = cfg_data_t'($urandom());
        roll = $urandom_range(0, 99);
        v[LEVEL_W-1:0] = LEVEL_W'(nervous_mix ? $urandom_range(230, 254) :
                         (roll < 10) ? 0 : (roll < 20) ? 255 : $urandom_range(150, 254));
        write_reg(REG_DAYLIGHT_LEVEL, v);

        write_reg(REG_BLIND_OTHER_TICKS, cfg_data_t'(nervous_mix ? $urandom_range(0, 2)
                                                                 : $urandom_range(0, 12)));
        write_reg(REG_BLIND_SELF_TICKS, cfg_data_t'($urandom_range(0, 12)));
        write_reg(REG_FLASH_HOLD_TICKS, cfg_data_t'($urandom_range(0, 8)));
        write_reg(REG_DAYLIGHT_HOLD_TICKS, cfg_data_t'($urandom_range(0, 8)));
    endtask

    function automatic level_t pick_sample(input int flash_pct, input int day_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < day_pct && day_reg < 255)
            return level_t'($urandom_range(day_reg + 1, 255));
        if (roll < day_pct + flash_pct && thr_reg < day_reg)
            return level_t'($urandom_range(thr_reg + 1, day_reg));
        if (roll < day_pct + flash_pct + 8)
            return level_t'($urandom_range(0, 255));
        return level_t'($urandom_range(0, (thr_reg > 255) ? 255 : thr_reg));
    endfunction

    task automatic check_field(input string name, input int want_v, input int got_v);
        if (want_v != got_v)
        begin
            errors++;
            $display("%0t: %s expected %0d got %0d", $time, name, want_v, got_v);
        end
    endtask

    // receiver side, long hold-off counted here
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_req)
            begin
                stall_left = LONG_STALL;
                stall_req  = 1'b0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        tick_result_t got;
        tick_result_t want;
        if (!rst_n || (in_valid && in_ready) || (cfg_valid && cfg_ready)
            || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (out_valid && out_ready)
        begin
            got = '{red_level, green_level, blue_level, fired, daylight_seen, holding,
                    nervous_level, power_level};
            if (tick_results_due.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing expected, power %0d", $time, power_level);
            end
            else
            begin
                want = tick_results_due.pop_front();
                check_field("red_level", want.red, got.red);
                check_field("green_level", want.green, got.green);
                check_field("blue_level", want.blue, got.blue);
                check_field("fired", want.fired, got.fired);
                check_field("daylight_seen", want.daylight, got.daylight);
                check_field("holding", want.holding, got.holding);
                check_field("nervous_level", want.nervous, got.nervous);
                check_field("power_level", want.power, got.power);
            end
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        int ph;
        int k;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 32;
        recv_idle_pct = 47;
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
            begin
                drain_ticks();
                write_reg(directed_rows[i].idx, directed_rows[i].data);
            end
            else
                send_tick(directed_rows[i].sample, directed_rows[i].typed,
                          directed_rows[i].want);
        end

        for (ph = 0; ph < PHASES; ph++)
        begin
            case (ph / 3)
                0:       begin send_idle_pct = 32; recv_idle_pct = 47; end
                1:       begin send_idle_pct = 47; recv_idle_pct = 32; end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase
            drain_ticks();
            program_phase(ph);
            for (k = 0; k < PHASE_TICKS; k++)
            begin
                if (k == 50)
                    stall_req = 1'b1;
                if (k == 100)
                    drain_ticks();
                send_tick((ph % 3 == 2) ? pick_sample(60, 2) : pick_sample(25, 5), 1'b0, '0);
            end
        end

        // widest register values with a zero flash threshold, then a daylight hold of full length
        drain_ticks();
        write_reg(REG_FLASH_THRESHOLD, 16'd0);
        write_reg(REG_DAYLIGHT_LEVEL, 16'd255);
        write_reg(REG_FIRE_LEVEL, 16'd65535);
        write_reg(REG_BOOST_AMOUNT, 16'd1023);
        write_reg(REG_BLIND_OTHER_TICKS, 16'd65535);
        write_reg(REG_BLIND_SELF_TICKS, 16'd65535);
        write_reg(REG_FLASH_HOLD_TICKS, 16'd65535);
        write_reg(REG_DAYLIGHT_HOLD_TICKS, 16'd65535);
        send_tick(8'd1, 1'b0, '0);
        repeat (LONG_COUNT) send_tick(8'd0, 1'b0, '0);
        drain_ticks();
        write_reg(REG_DAYLIGHT_LEVEL, 16'd0);
        send_tick(8'd255, 1'b0, '0);
        repeat (LONG_COUNT) send_tick(level_t'($urandom_range(0, 255)), 1'b0, '0);

        drain_ticks();
        repeat (10) @(posedge clk);
        if (errors == 0 && tick_results_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
